/* sv/akt_pkg.sv */
// ----------------------------------------------------------------------------
// akt_pkg
// Shared types and constants of the analog key travel trigger.
// ----------------------------------------------------------------------------
package akt_pkg;

    localparam int KEYS        = 16;
    localparam int SAMPLE_BITS = 12;
    localparam int KEY_W       = 4;
    localparam int DZ_W        = 8;
    localparam int SET_W       = 8;
    localparam int TRIG_STEPS  = 36;
    localparam int QDEPTH      = 2;

    // reciprocals for the divides by 37 and 38, shift 24
    localparam int RECIP_SH = 24;
    localparam logic [18:0] RECIP_37 = 19'd453439;
    localparam logic [18:0] RECIP_38 = 19'd441506;
    localparam logic [5:0]  DIV_ON   = 6'd37;
    localparam logic [5:0]  DIV_OFF  = 6'd38;

    typedef enum logic [1:0] {
        CMD_LOAD     = 2'd0,
        CMD_DISCOVER = 2'd1,
        CMD_SAMPLE   = 2'd2,
        CMD_NOP      = 2'd3
    } t_cmd;

    typedef enum logic {
        REG_THRESHOLD = 1'b0,
        REG_DEAD_ZONE = 1'b1
    } t_reg;

    typedef struct packed {
        t_cmd                   cmd;
        logic                   key_ok;
        logic [KEY_W-1:0]       key;
        logic [SAMPLE_BITS-1:0] reading;
        logic [SAMPLE_BITS-1:0] rest;
        logic [SAMPLE_BITS-1:0] pressed;
        logic [5:0]             on_m;
        logic [5:0]             off_m;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ON_MUL,
        ST_ON_FIX,
        ST_OFF_MUL,
        ST_OFF_FIX,
        ST_DECIDE,
        ST_OUT
    } t_state;

    // setting mod 36, at most seven compare-subtract steps on 8 bits
    function automatic logic [5:0] mod36(input logic [SET_W-1:0] x);
        logic [SET_W-1:0] v;
        v = x;
        for (int i = 0; i < 7; i++) begin
            if (v >= SET_W'(TRIG_STEPS)) begin
                v = v - SET_W'(TRIG_STEPS);
            end
        end
        return v[5:0];
    endfunction

endpackage

/* sv/akt_front.sv */
// ----------------------------------------------------------------------------
// akt_front
// Accepts input words, checks the key index, reduces trigger settings.
// ----------------------------------------------------------------------------
module akt_front (
    input  logic                            i_tvalid,
    output logic                            o_tready,
    input  logic [55:0]                     i_tdata,
    input  logic [1:0]                      i_tuser,
    input  akt_pkg::t_qstat                 i_qstat,
    output logic                            o_push,
    output akt_pkg::t_item                  o_item
);

    logic [akt_pkg::KEY_W-1:0] w_key;

    assign w_key    = i_tdata[3:0];
    assign o_tready = !i_qstat.full;
    assign o_push   = i_tvalid && !i_qstat.full;

    always_comb begin
        o_item.cmd     = akt_pkg::t_cmd'(i_tuser);
        o_item.key     = w_key;
        o_item.key_ok  = (int'(w_key) < akt_pkg::KEYS);
        o_item.reading = i_tdata[15:4];
        o_item.rest    = i_tdata[27:16];
        o_item.pressed = i_tdata[39:28];
        o_item.on_m    = akt_pkg::mod36(i_tdata[47:40]);
        o_item.off_m   = akt_pkg::mod36(i_tdata[55:48]);
    end

endmodule

/* sv/akt_queue.sv */
// ----------------------------------------------------------------------------
// akt_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module akt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  akt_pkg::t_item  i_item,
    input  logic            i_pop,
    output akt_pkg::t_item  o_item,
    output akt_pkg::t_qstat o_qstat
);

    akt_pkg::t_item r_mem [akt_pkg::QDEPTH];
    logic           r_wp, n_wp;
    logic           r_rp, n_rp;
    logic [1:0]     r_cnt, n_cnt;

    always_comb begin
        n_wp  = i_push ? !r_wp : r_wp;
        n_rp  = i_pop  ? !r_rp : r_rp;
        n_cnt = r_cnt + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_item        = r_mem[r_rp];
    assign o_qstat.full  = (r_cnt == 2'(akt_pkg::QDEPTH));
    assign o_qstat.empty = (r_cnt == 2'd0);

endmodule

/* sv/akt_back.sv */
// ----------------------------------------------------------------------------
// akt_back
// Key state, calibration store, travel, trigger levels and result word.
// ----------------------------------------------------------------------------
module akt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic            i_cfg_index,
    input  logic [11:0]     i_cfg_data,
    input  akt_pkg::t_item  i_item,
    input  akt_pkg::t_qstat i_qstat,
    output logic            o_pop,
    output logic            o_tvalid,
    input  logic            i_tready,
    output logic [63:0]     o_tdata
);

    localparam int SB = akt_pkg::SAMPLE_BITS;
    localparam int K  = akt_pkg::KEYS;

    akt_pkg::t_state r_state, n_state;
    akt_pkg::t_item  r_it;

    logic [11:0]            r_thr;
    logic [akt_pkg::DZ_W-1:0] r_dz;

    logic [K-1:0]  r_present;
    logic [K-1:0]  r_down;
    logic [SB-1:0] r_rest    [K];
    logic [SB-1:0] r_pressed [K];
    logic [5:0]    r_on_m    [K];
    logic [5:0]    r_off_m   [K];

    logic [SB-1:0] r_travel;
    logic [SB-1:0] r_range;
    logic [17:0]   r_p;
    logic [12:0]   r_q;
    logic [SB-1:0] r_on;
    logic [SB-1:0] r_off;
    logic [19:0]   r_rem;
    logic [7:0]    r_dq;
    logic [3:0]    r_dcnt;

    logic          r_ovalid;
    logic [SB-1:0] r_otravel;
    logic [7:0]    r_otbyte;
    logic [SB-1:0] r_res_travel;
    logic [7:0]    r_res_tbyte;
    logic [63:0]   r_odata;

    logic w_out_free;
    logic w_live;
    logic w_sample;

    // travel path
    logic signed [SB+1:0] w_up, w_dn, w_rs, w_ts, w_rng, w_tt, w_tc;
    logic [36:0]          w_prod;
    logic [17:0]          w_back;
    logic [12:0]          w_qc;
    logic [19:0]          w_sh;

    assign w_out_free = !r_ovalid || i_tready;
    assign w_live     = r_it.key_ok;
    assign w_sample   = w_live && (r_it.cmd == akt_pkg::CMD_SAMPLE) && r_present[r_it.key];

    always_comb begin
        w_up  = $signed({2'b00, r_rest[r_it.key]});
        w_dn  = $signed({2'b00, r_pressed[r_it.key]});
        w_rs  = w_dn - w_up;
        w_ts  = $signed({2'b00, r_it.reading}) - w_up;
        w_rng = (w_rs < 0) ? -w_rs : w_rs;
        w_tt  = (w_rs < 0) ? -w_ts : w_ts;
        if (w_tt < $signed({6'b0, r_dz})) begin
            w_tc = '0;
        end else if (w_tt > w_rng) begin
            w_tc = w_rng;
        end else begin
            w_tc = w_tt;
        end
    end

    always_comb begin
        w_prod = (r_state == akt_pkg::ST_ON_MUL) ? 37'(r_p * akt_pkg::RECIP_37)
                                                 : 37'(r_p * akt_pkg::RECIP_38);
        w_back = (r_state == akt_pkg::ST_ON_FIX) ? 18'(r_q * akt_pkg::DIV_ON)
                                                 : 18'(r_q * akt_pkg::DIV_OFF);
        w_qc   = (w_back > r_p) ? r_q - 13'd1 : r_q;
        w_sh   = 20'(r_range) << (r_dcnt[2:0] - 3'd1);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            akt_pkg::ST_IDLE:    if (!i_qstat.empty) n_state = akt_pkg::ST_EXEC;
            akt_pkg::ST_EXEC:    n_state = w_sample ? akt_pkg::ST_ON_MUL : akt_pkg::ST_OUT;
            akt_pkg::ST_ON_MUL:  n_state = akt_pkg::ST_ON_FIX;
            akt_pkg::ST_ON_FIX:  n_state = akt_pkg::ST_OFF_MUL;
            akt_pkg::ST_OFF_MUL: n_state = akt_pkg::ST_OFF_FIX;
            akt_pkg::ST_OFF_FIX: n_state = akt_pkg::ST_DECIDE;
            akt_pkg::ST_DECIDE:  if (r_dcnt == 4'd0) n_state = akt_pkg::ST_OUT;
            akt_pkg::ST_OUT:     if (w_out_free) n_state = akt_pkg::ST_IDLE;
            default:             n_state = akt_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop = 1'b0;
        case (r_state)
            akt_pkg::ST_IDLE: o_pop = !i_qstat.empty;
            default:          o_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= akt_pkg::ST_IDLE;
            r_present <= '0;
            r_down    <= '0;
            r_thr     <= 12'd500;
            r_dz      <= 8'd8;
            r_ovalid  <= 1'b0;
            r_dcnt    <= 4'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (akt_pkg::t_reg'(i_cfg_index))
                    akt_pkg::REG_THRESHOLD: r_thr <= i_cfg_data;
                    akt_pkg::REG_DEAD_ZONE: r_dz  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (r_state == akt_pkg::ST_EXEC && w_live) begin
                case (r_it.cmd)
                    akt_pkg::CMD_DISCOVER: begin
                        r_present[r_it.key] <= (r_it.reading > r_thr);
                        if (!(r_it.reading > r_thr)) r_down[r_it.key] <= 1'b0;
                    end
                    akt_pkg::CMD_SAMPLE: begin
                        if (!r_present[r_it.key]) r_down[r_it.key] <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (r_state == akt_pkg::ST_EXEC) begin
                r_dcnt <= w_sample ? 4'd8 : 4'd0;
            end else if (r_dcnt != 4'd0) begin
                r_dcnt <= r_dcnt - 4'd1;
            end
            if (r_state == akt_pkg::ST_DECIDE && r_dcnt == 4'd0) begin
                r_down[r_it.key] <= r_down[r_it.key] ? (r_travel > r_off)
                                                     : (r_travel >= r_on);
            end
            if (r_state == akt_pkg::ST_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_it <= i_item;
        end
        if (r_state == akt_pkg::ST_EXEC && w_live && r_it.cmd == akt_pkg::CMD_LOAD) begin
            r_rest[r_it.key]    <= r_it.rest;
            r_pressed[r_it.key] <= r_it.pressed;
            r_on_m[r_it.key]    <= r_it.on_m;
            r_off_m[r_it.key]   <= r_it.off_m;
        end
        case (r_state)
            akt_pkg::ST_EXEC: begin
                r_travel     <= w_tc[SB-1:0];
                r_range      <= w_rng[SB-1:0];
                r_p          <= 18'({1'b0, r_on_m[r_it.key]} + 7'd1) * 18'(w_rng[SB-1:0]);
                r_rem        <= 20'(w_tc[SB-1:0]) * 20'd255;
                r_dq         <= 8'd0;
                r_res_travel <= '0;
                r_res_tbyte  <= '0;
            end
            akt_pkg::ST_ON_MUL, akt_pkg::ST_OFF_MUL: begin
                r_q <= w_prod[36:akt_pkg::RECIP_SH];
            end
            akt_pkg::ST_ON_FIX: begin
                r_on <= w_qc[SB-1:0];
                r_p  <= 18'(6'(akt_pkg::TRIG_STEPS) - r_off_m[r_it.key]) * 18'(w_qc[SB-1:0]);
            end
            akt_pkg::ST_OFF_FIX: begin
                r_off <= w_qc[SB-1:0];
            end
            akt_pkg::ST_DECIDE: begin
                r_res_travel <= r_travel;
                r_res_tbyte  <= (r_range == '0) ? 8'd0 : r_dq;
            end
            default: ;
        endcase
        if (r_state != akt_pkg::ST_EXEC && r_dcnt != 4'd0 && r_rem >= w_sh) begin
            r_rem                     <= r_rem - w_sh;
            r_dq[r_dcnt[2:0] - 3'd1]  <= 1'b1;
        end
        if (r_state == akt_pkg::ST_OUT && w_out_free) begin
            r_otravel <= r_res_travel;
            r_otbyte  <= r_res_tbyte;
            r_odata   <= {6'b0,
                          r_present[15:0],
                          r_down[15:0],
                          r_res_tbyte,
                          r_res_travel,
                          w_live && r_down[r_it.key],
                          w_live && r_present[r_it.key],
                          r_it.key};
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = {r_odata[63:26], r_otbyte, r_otravel, r_odata[5:0]};

endmodule

/* sv/analog_key_travel_trigger.sv */
// ----------------------------------------------------------------------------
// analog_key_travel_trigger
// Hall-sensor key travel and actuation with hysteresis, sixteen keys.
// ----------------------------------------------------------------------------
// Each input word yields one result word. Loads, discovery samples and
// samples of absent keys go from execution straight to output; a sample
// of a present key first passes the constant-reciprocal trigger level
// steps and the eight-step travel byte divider that runs beside them. A
// two-word queue separates input acceptance from execution and the result
// sits in an output register, so input is taken while a result waits.
// Config writes are always accepted and belong in idle time.
module analog_key_travel_trigger (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // key, reading, rest_level, pressed_level, on_setting, off_setting
    input  logic [55:0] s_axis_tdata,
    // cmd
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // key_out, present, actuated, travel, travel_byte, actuated_map, presence_map
    output logic [63:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    akt_pkg::t_item  w_fitem, w_qitem;
    akt_pkg::t_qstat w_qstat;
    logic            w_push, w_pop;

    assign o_cfg_ready = 1'b1;

    akt_front u_front (
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_qstat  (w_qstat),
        .o_push   (w_push),
        .o_item   (w_fitem)
    );

    akt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .i_pop   (w_pop),
        .o_item  (w_qitem),
        .o_qstat (w_qstat)
    );

    akt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (w_qitem),
        .i_qstat     (w_qstat),
        .o_pop       (w_pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata)
    );

endmodule

/* sv/akt_checker.sv */
// ----------------------------------------------------------------------------
// akt_checker
// Port-level checks of the key travel trigger.
// ----------------------------------------------------------------------------
module akt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result word after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    a_act_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[41:26] & ~m_axis_tdata[57:42]) == 16'd0))
        else $error("actuated key not present");

    a_tbyte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[17:6] == 12'd0) |-> (m_axis_tdata[25:18] == 8'd0))
        else $error("travel byte without travel");

endmodule

bind analog_key_travel_trigger akt_checker u_akt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for analog_key_travel_trigger. A scoreboard class
// predicts each result word from the accepted input words and checks the
// output stream field by field. Bursty input, patterned output stalls, and
// register writes between phases. The fixed-point reciprocals of the block
// are checked against plain integer division.
// ----------------------------------------------------------------------------

class key_scoreboard;
    logic [11:0] thr;
    logic [7:0]  dz;
    bit          pres [16];
    bit          down [16];
    int          rest_lv [16];
    int          press_lv [16];
    int          on_set [16];
    int          off_set [16];
    logic [63:0] expq [$];
    int          errors;

    function new();
        thr = 12'd500;
        dz = 8'd8;
        errors = 0;
        foreach (pres[i]) begin
            pres[i] = 0;
            down[i] = 0;
        end
    endfunction

    function void set_reg(akt_pkg::t_reg idx, logic [11:0] val);
        if (idx == akt_pkg::REG_THRESHOLD) begin
            thr = val;
        end else begin
            dz = val[7:0];
        end
    endfunction

    function void note_input(logic [1:0] cmd, logic [55:0] d);
        int k, rd, rng, t, on_l, off_l, trav, tbyte;
        logic [15:0] am, pm;
        k = d[3:0];
        rd = d[15:4];
        trav = 0;
        tbyte = 0;
        if (cmd == akt_pkg::CMD_LOAD) begin
            rest_lv[k] = d[27:16];
            press_lv[k] = d[39:28];
            on_set[k] = d[47:40];
            off_set[k] = d[55:48];
        end else if (cmd == akt_pkg::CMD_DISCOVER) begin
            pres[k] = rd > thr;
            if (!pres[k]) down[k] = 0;
        end else if (cmd == akt_pkg::CMD_SAMPLE) begin
            if (!pres[k]) begin
                down[k] = 0;
            end else begin
                rng = press_lv[k] - rest_lv[k];
                t = rd - rest_lv[k];
                if (rng < 0) begin
                    rng = -rng;
                    t = -t;
                end
                if (t < int'(dz)) t = 0;
                else if (t > rng) t = rng;
                trav = t;
                tbyte = (rng != 0) ? (trav * 255) / rng : 0;
                on_l = ((on_set[k] % 36) + 1) * rng / 37;
                off_l = (36 - off_set[k] % 36) * on_l / 38;
                if (down[k]) down[k] = trav > off_l;
                else down[k] = trav >= on_l;
            end
        end
        for (int i = 0; i < 16; i++) begin
            am[i] = down[i];
            pm[i] = pres[i];
        end
        expq.push_back({6'd0, pm, am, tbyte[7:0], trav[11:0], down[k], pres[k], k[3:0]});
    endfunction

    function void split(logic [63:0] w, output int f [7]);
        f[0] = w[3:0];
        f[1] = w[4];
        f[2] = w[5];
        f[3] = w[17:6];
        f[4] = w[25:18];
        f[5] = w[41:26];
        f[6] = w[63:42];
    endfunction

    function void check_result(logic [63:0] act);
        logic [63:0] ex;
        int fe [7];
        int fa [7];
        string names [7];
        names = '{"key_out", "present", "actuated", "travel", "travel_byte",
                  "actuated_map", "presence_map"};
        if (expq.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, act);
            errors++;
            return;
        end
        ex = expq.pop_front();
        split(ex, fe);
        split(act, fa);
        for (int i = 0; i < 7; i++) begin
            if (fe[i] != fa[i]) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, names[i], fe[i], fa[i]);
                errors++;
            end
        end
    endfunction
endclass

module testbench;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [11:0] i_cfg_data = '0;

    key_scoreboard sb = new();
    int burst_left = 0;
    int cyc = 0;
    int rx_mode = 0;

    analog_key_travel_trigger u_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver stall pattern: always ready, random, or mostly stalled, mode redrawn at random
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc % 64 == 0) rx_mode <= $urandom_range(0, 2);
        case (rx_mode)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_axis_tready <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    always @(negedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    task automatic send_word(logic [1:0] cmd, logic [3:0] k, logic [11:0] rd,
                             logic [11:0] rl, logic [11:0] pl, logic [7:0] on_s,
                             logic [7:0] off_s);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {off_s, on_s, pl, rl, rd, k};
        forever begin
            @(negedge i_clk);
            if (s_axis_tready) break;
        end
        sb.note_input(cmd, {off_s, on_s, pl, rl, rd, k});
        @(posedge i_clk);
    endtask

    task automatic write_reg(akt_pkg::t_reg idx, logic [11:0] val);
        s_axis_tvalid <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        forever begin
            @(negedge i_clk);
            if (o_cfg_ready) break;
        end
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expq.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        logic [1:0]  cmd;
        logic [3:0]  k;
        logic [11:0] rd;
        int r, lo, hi;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            k = 4'($urandom);
            cmd = (r < 12) ? akt_pkg::CMD_LOAD : (r < 30) ? akt_pkg::CMD_DISCOVER
                  : (r < 95) ? akt_pkg::CMD_SAMPLE : akt_pkg::CMD_NOP;
            lo = sb.rest_lv[k];
            hi = sb.press_lv[k];
            if (lo > hi) begin
                lo = sb.press_lv[k];
                hi = sb.rest_lv[k];
            end
            if (cmd == akt_pkg::CMD_DISCOVER && r < 25) begin
                rd = 12'(int'(sb.thr) + $urandom_range(0, 2) - 1);
            end else if (cmd == akt_pkg::CMD_SAMPLE && r < 85) begin
                rd = 12'($urandom_range(lo, hi));
            end else begin
                rd = 12'($urandom);
            end
            send_word(cmd, k, rd, 12'($urandom), 12'($urandom), 8'($urandom),
                      8'($urandom));
        end
    endtask

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // load every key first, with extreme and reversed calibrations
        send_word(akt_pkg::CMD_LOAD, 4'd0, 12'd0, 12'd0, 12'd4095, 8'd0, 8'd0);
        send_word(akt_pkg::CMD_LOAD, 4'd1, 12'd0, 12'd4095, 12'd0, 8'd35, 8'd35);
        send_word(akt_pkg::CMD_LOAD, 4'd2, 12'd0, 12'd2000, 12'd2000, 8'd36, 8'd255);
        send_word(akt_pkg::CMD_LOAD, 4'd3, 12'hfff, 12'd100, 12'd3000, 8'd255, 8'd36);
        for (int i = 4; i < 16; i++) begin
            send_word(akt_pkg::CMD_LOAD, 4'(i), 12'($urandom), 12'($urandom),
                      12'($urandom), 8'($urandom), 8'($urandom));
        end
        send_word(akt_pkg::CMD_DISCOVER, 4'd0, 12'd4095, 12'd0, 12'd0, 8'd0, 8'd0);
        send_word(akt_pkg::CMD_DISCOVER, 4'd1, 12'd501, 12'd0, 12'd0, 8'd0, 8'd0);
        send_word(akt_pkg::CMD_DISCOVER, 4'd2, 12'd1000, 12'd0, 12'd0, 8'd0, 8'd0);
        send_word(akt_pkg::CMD_SAMPLE, 4'd0, 12'd4095, 12'd0, 12'd0, 8'd0, 8'd0);
        send_word(akt_pkg::CMD_SAMPLE, 4'd1, 12'd0, 12'd0, 12'd0, 8'd0, 8'd0);
        send_word(akt_pkg::CMD_SAMPLE, 4'd2, 12'd3000, 12'd0, 12'd0, 8'd0, 8'd0);
        send_word(akt_pkg::CMD_NOP, 4'd0, 12'hfff, 12'hfff, 12'hfff, 8'hff, 8'hff);
        send_word(akt_pkg::CMD_DISCOVER, 4'd0, 12'd500, 12'd0, 12'd0, 8'd0, 8'd0);
        send_word(akt_pkg::CMD_SAMPLE, 4'd0, 12'd4095, 12'd0, 12'd0, 8'd0, 8'd0);
        drain();
        random_phase(120);
        drain();
        write_reg(akt_pkg::REG_THRESHOLD, 12'd0);
        write_reg(akt_pkg::REG_DEAD_ZONE, 12'd0);
        random_phase(110);
        drain();
        write_reg(akt_pkg::REG_THRESHOLD, 12'd4095);
        write_reg(akt_pkg::REG_DEAD_ZONE, 12'd255);
        random_phase(60);
        drain();
        write_reg(akt_pkg::REG_THRESHOLD, 12'($urandom_range(0, 2000)));
        write_reg(akt_pkg::REG_DEAD_ZONE, 12'($urandom_range(0, 40)));
        random_phase(140);
        drain();
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
